// File: design/bra_pkg.sv
// shared types and constants for the bitmap range allocator
`default_nettype none
package bra_pkg;
  localparam int MapBits   = 4096;
  localparam int WordBits  = 64;
  localparam int NumWords  = MapBits / WordBits;
  localparam int WordIdxW  = $clog2(NumWords);
  localparam int BitIdxW   = $clog2(WordBits);
  localparam int PosW      = 12;
  localparam int CntW      = 13;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_ALLOC = 2'd3;

  localparam logic [CntW-1:0] MAP_SIZE_RESET = 13'd4096;

  typedef struct packed {
    logic [1:0]      operation;
    logic [PosW-1:0] position;
    logic [CntW-1:0] count;
  } req_t;

  typedef struct packed {
    logic            bit_value;
    logic            found;
    logic [PosW-1:0] run_start;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_RUN, ST_SCAN, ST_MARK, ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;    // write zero word at sweep address, advance
    logic load;        // capture request
    logic rd_issue;    // read word at current address
    logic run_step;    // apply run to fetched word, write back
    logic scan_step;   // examine fetched word
    logic mark_start;  // begin marking found run
    logic rsp_load;    // latch result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic run_last;
    logic scan_hit;
    logic scan_end;
    logic alloc_zero;
  } sts_t;
endpackage
`default_nettype wire

// File: design/bra_ctrl.sv
// sequencing state machine for the bitmap range allocator
`default_nettype none
module bra_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  wire [1:0]        in_op,
  output logic             in_stall,
  output logic             out_valid,
  input  wire              out_stall,
  input  wire bra_pkg::sts_t sts,
  output bra_pkg::cmd_t    cmd
);
  bra_pkg::state_t state, state_next;
  logic fetched, fetched_next;

  // next state
  always_comb begin
    state_next   = state;
    fetched_next = fetched;
    unique case (state)
      bra_pkg::ST_CLEAR: if (sts.clr_last) state_next = bra_pkg::ST_IDLE;
      bra_pkg::ST_IDLE: begin
        if (in_valid && !(out_valid && out_stall)) begin
          fetched_next = 1'b0;
          unique case (in_op)
            bra_pkg::OP_READ:  state_next = bra_pkg::ST_READ;
            bra_pkg::OP_ALLOC: state_next = bra_pkg::ST_SCAN;
            default:           state_next = bra_pkg::ST_RUN;
          endcase
        end
      end
      bra_pkg::ST_READ: begin
        if (!fetched) fetched_next = 1'b1;
        else state_next = bra_pkg::ST_DONE;
      end
      bra_pkg::ST_RUN: begin
        if (!fetched) fetched_next = 1'b1;
        else if (sts.run_last) state_next = bra_pkg::ST_DONE;
        else fetched_next = 1'b0;
      end
      bra_pkg::ST_SCAN: begin
        if (sts.alloc_zero) state_next = bra_pkg::ST_DONE;
        else if (!fetched) fetched_next = 1'b1;
        else if (sts.scan_hit) begin
          state_next = bra_pkg::ST_RUN;
          fetched_next = 1'b0;
        end else if (sts.scan_end) state_next = bra_pkg::ST_DONE;
        else fetched_next = 1'b0;
      end
      bra_pkg::ST_DONE: state_next = bra_pkg::ST_IDLE;
      default: state_next = bra_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      bra_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      bra_pkg::ST_IDLE: begin
        in_stall = out_valid && out_stall;
        cmd.load = in_valid && !(out_valid && out_stall);
      end
      bra_pkg::ST_READ: cmd.rd_issue = !fetched;
      bra_pkg::ST_RUN: begin
        cmd.rd_issue = !fetched;
        cmd.run_step = fetched;
      end
      bra_pkg::ST_SCAN: begin
        cmd.rd_issue  = !fetched && !sts.alloc_zero;
        cmd.scan_step = fetched;
        cmd.mark_start = fetched && sts.scan_hit;
      end
      bra_pkg::ST_DONE: cmd.rsp_load = 1'b1;
      default: ;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bra_pkg::ST_CLEAR;
      fetched <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fetched <= fetched_next;
      if (cmd.rsp_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: design/bra_dp.sv
// bitmap memory, run masking and free-run scan for the allocator
`default_nettype none
module bra_dp (
  input  wire                      clk,
  input  wire                      rst,
  input  wire bra_pkg::req_t       req,
  input  wire [bra_pkg::CntW-1:0]  map_size,
  input  wire bra_pkg::cmd_t       cmd,
  output bra_pkg::sts_t            sts,
  output bra_pkg::rsp_t            rsp
);
  localparam int WI = bra_pkg::WordIdxW;
  localparam int BI = bra_pkg::BitIdxW;
  localparam int SW = WI + BI + 2;  // wide enough for any end position

  logic [bra_pkg::WordBits-1:0] mem [bra_pkg::NumWords];
  logic [bra_pkg::WordBits-1:0] rdata;

  logic [1:0]            op;
  logic                  set_val;
  logic [SW-1:0]         run_lo, run_hi;   // run covers run_lo .. run_hi-1
  logic [bra_pkg::CntW-1:0] cnt;
  logic [WI-1:0]         addr;
  logic [SW-1:0]         runlen;
  logic [SW-1:0]         limit;
  logic                  found;
  logic [bra_pkg::PosW-1:0] start;

  // per-word scan results
  logic [SW-1:0] base, len_c, lim_rel;
  logic          hit_c;
  logic [SW-1:0] hit_pos;
  logic [bra_pkg::WordBits-1:0] rmask;
  logic [SW-1:0] lo_rel, hi_rel;

  assign base = SW'({addr, {BI{1'b0}}});

  // free-run scan across one word: run ending at each bit from last blocked bit
  always_comb begin
    logic [BI-1:0] last;
    logic          seen;
    logic          h;
    logic          blk;
    logic [SW-1:0] run_b;
    last = '0;
    seen = 1'b0;
    h = 1'b0;
    blk = 1'b0;
    run_b = '0;
    hit_pos = '0;
    lim_rel = (limit > base) ? (limit - base) : '0;
    for (int b = 0; b < bra_pkg::WordBits; b++) begin
      blk = rdata[b] || (SW'(b) >= lim_rel);
      if (blk) begin
        seen = 1'b1;
        last = BI'(b);
      end
      run_b = seen ? (SW'(b) - SW'(last)) : (runlen + SW'(b) + 1'b1);
      if (!h && (run_b >= SW'(cnt))) begin
        h = 1'b1;
        hit_pos = base + SW'(b) + 1'b1 - SW'(cnt);
      end
    end
    len_c = run_b;
    hit_c = h;
  end

  // mask for the run within the current word
  always_comb begin
    lo_rel = (run_lo > base) ? (run_lo - base) : '0;
    hi_rel = (run_hi > base) ? (run_hi - base) : '0;
    for (int b = 0; b < bra_pkg::WordBits; b++)
      rmask[b] = (SW'(b) >= lo_rel) && (SW'(b) < hi_rel);
  end

  always_comb begin
    sts.clr_last   = (addr == WI'(bra_pkg::NumWords - 1));
    sts.run_last   = (addr == WI'(bra_pkg::NumWords - 1)) ||
                     (base + SW'(bra_pkg::WordBits) >= run_hi);
    sts.scan_hit   = hit_c;
    sts.scan_end   = (addr == WI'(bra_pkg::NumWords - 1)) ||
                     (base + SW'(bra_pkg::WordBits) >= limit);
    sts.alloc_zero = (cnt == '0);
  end

  // memory port
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rdata <= mem[addr];
    if (cmd.clr_step) mem[addr] <= '0;
    else if (cmd.run_step)
      mem[addr] <= set_val ? (rdata | rmask) : (rdata & ~rmask);
  end

  // request and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.clr_step) begin
      addr <= sts.clr_last ? '0 : addr + 1'b1;
    end else if (cmd.load) begin
      op      <= req.operation;
      set_val <= (req.operation != bra_pkg::OP_CLEAR);
      cnt     <= (req.operation == bra_pkg::OP_ALLOC) ? req.count : '0;
      run_lo  <= SW'(req.position);
      run_hi  <= (req.count == '0) ? SW'(req.position) :
                 SW'(req.position) + SW'(req.count);
      addr    <= (req.operation == bra_pkg::OP_ALLOC) ? '0 :
                 req.position[bra_pkg::PosW-1:BI];
      runlen  <= '0;
      limit   <= (map_size > bra_pkg::CntW'(bra_pkg::MapBits)) ?
                 SW'(bra_pkg::MapBits) : SW'(map_size);
      found   <= 1'b0;
      start   <= '0;
    end else if (cmd.mark_start) begin
      found  <= 1'b1;
      start  <= bra_pkg::PosW'(hit_pos);
      run_lo <= hit_pos;
      run_hi <= hit_pos + SW'(cnt);
      set_val <= 1'b1;
      addr   <= WI'(hit_pos[SW-1:BI]);
    end else if (cmd.scan_step) begin
      runlen <= len_c;
      addr   <= addr + 1'b1;
    end else if (cmd.run_step) begin
      addr <= addr + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      rsp.bit_value <= (op == bra_pkg::OP_READ) ? rdata[run_lo[BI-1:0]] : 1'b0;
      rsp.found     <= (op == bra_pkg::OP_ALLOC) && (found || cnt == '0);
      rsp.run_start <= (op == bra_pkg::OP_ALLOC) ? start : '0;
    end
  end
endmodule
`default_nettype wire

// File: design/bitmap_range_allocator.sv
// top level of the bitmap range allocator
//
// Input channel in_valid/in_stall carries one request beat (operation,
// position, count); output channel out_valid/out_stall carries one result
// beat per request. map_size is written through the APB port at 0x0.
// After reset a clearing pass zeroes the 64-word bitmap, one word a cycle,
// while in_stall stays high; map_size returns to 4096.
// Each operation uses the single memory port one word at a time: each
// word is read, then examined or rewritten. A read fetches its word once;
// set/clear rewrites each word touched; allocate scans words from word 0
// and then marks the words of the run it found.
// One request is in flight at a time. A finished result waits in the
// output register while out_stall is high; a new request is taken only
// once that result can leave.
`default_nettype none
module bitmap_range_allocator (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire bra_pkg::req_t in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output bra_pkg::rsp_t      out_data,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [1:0]          paddr,
  input  wire [31:0]         pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [bra_pkg::CntW-1:0] map_size;
  bra_pkg::cmd_t cmd;
  bra_pkg::sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(map_size) : 32'd0;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) map_size <= bra_pkg::MAP_SIZE_RESET;
    else if (psel && penable && pwrite && paddr == 2'd0)
      map_size <= pwdata[bra_pkg::CntW-1:0];
  end

  bra_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_op(in_data.operation), .in_stall,
    .out_valid, .out_stall, .sts, .cmd
  );

  bra_dp u_dp (
    .clk, .rst, .req(in_data), .map_size, .cmd, .sts, .rsp(out_data)
  );
endmodule
`default_nettype wire

// File: design/bra_checker.sv
// port-level checks for the bitmap range allocator
`default_nettype none
module bra_checker (
  input wire                clk,
  input wire                rst,
  input wire                in_valid,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input wire bra_pkg::rsp_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("second beat taken early");
  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.run_start == '0) else $error("start without find");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> !out_data.bit_value) else $error("mixed result");
endmodule
bind bitmap_range_allocator bra_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire
